@@ rtl/tcw_pkg.sv @@
// Shared constants, types and helpers of the text console writer.
// Depends on nothing; imported by tcw_cursor_step and text_console_writer_unit.
`default_nettype none

package tcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int CELL_W  = $clog2(CELLS);
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;

   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic CSR_DEFAULT_ATTR = 1'b0;
   localparam logic CSR_ERROR_ATTR   = 1'b1;

   localparam logic [7:0] CH_BACKSPACE = 8'h08;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_ERROR     = 8'h45;
   localparam logic [7:0] CH_BLANK     = 8'h00;

   localparam logic [7:0] DEFAULT_ATTR_RESET = 8'd15;
   localparam logic [7:0] ERROR_ATTR_RESET   = 8'd244;

   // What one item does to the cell store and the cursor.
   typedef struct packed {
      logic              coord_error;
      logic              wr_en;
      logic [CELL_W-1:0] wr_addr;
      logic [15:0]       wr_data;
      logic              rd_en;
      logic [CELL_W-1:0] rd_addr;
      logic              scroll;
      logic              clear;
      logic [COL_W-1:0]  next_col;
      logic [ROW_W-1:0]  next_row;
   } step_type;

   function automatic logic [CELL_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
      logic [CELL_W-1:0] base;
      base = CELL_W'(r) * CELL_W'(COLUMNS);
      return base + CELL_W'(c);
   endfunction

endpackage

`default_nettype wire

@@ rtl/tcw_cursor_step.sv @@
// Decodes one console item: target cell, coordinate check, cell write and
// the cursor position that follows. Depends on tcw_pkg.
`default_nettype none

module tcw_cursor_step
   import tcw_pkg::*;
(
   input  wire logic [1:0]       op,
   input  wire logic [7:0]       char_code,
   input  wire logic [7:0]       attr,
   input  wire logic [COL_W-1:0] col,
   input  wire logic [ROW_W-1:0] row,
   input  wire logic             use_cursor,
   input  wire logic [COL_W-1:0] cur_col,
   input  wire logic [ROW_W-1:0] cur_row,
   input  wire logic [7:0]       default_attr,
   input  wire logic [7:0]       error_attr,
   output step_type              step
);

   localparam logic [COL_W:0] COL_LIMIT = (COL_W+1)'(COLUMNS);
   localparam logic [ROW_W:0] ROW_LIMIT = (ROW_W+1)'(ROWS);

   logic             bad;
   logic [COL_W-1:0] tgt_col;
   logic [ROW_W-1:0] tgt_row;
   logic [7:0]       put_attr;
   logic [CELL_W-1:0] tgt_addr;
   logic [ROW_W:0]   new_row;

   always_comb begin
      bad      = !use_cursor && (({1'b0, col} >= COL_LIMIT) || ({1'b0, row} >= ROW_LIMIT));
      tgt_col  = use_cursor ? cur_col : col;
      tgt_row  = use_cursor ? cur_row : row;
      put_attr = (attr == 8'd0) ? default_attr : attr;
      tgt_addr = cell_addr(tgt_row, tgt_col);
      new_row  = {1'b0, tgt_row};

      step             = '0;
      step.next_col    = cur_col;
      step.next_row    = cur_row;
      step.rd_addr     = tgt_addr;
      step.wr_addr     = tgt_addr;

      case (op)
         OP_PUT: begin
            if (bad) begin
               step.coord_error = 1'b1;
               step.wr_en       = 1'b1;
               step.wr_addr     = CELL_W'(CELLS - 1);
               step.wr_data     = {error_attr, CH_ERROR};
            end else begin
               step.next_col = tgt_col;
               if (char_code == CH_NEWLINE) begin
                  step.next_col = '0;
                  new_row       = {1'b0, tgt_row} + 1'b1;
               end else if (char_code == CH_BACKSPACE) begin
                  step.wr_en   = 1'b1;
                  step.wr_data = {put_attr, CH_SPACE};
               end else begin
                  step.wr_en   = 1'b1;
                  step.wr_data = {put_attr, char_code};
                  if (tgt_col == COL_W'(COLUMNS - 1)) begin
                     step.next_col = '0;
                     new_row       = {1'b0, tgt_row} + 1'b1;
                  end else begin
                     step.next_col = tgt_col + 1'b1;
                  end
               end
               // Running off the bottom row scrolls and keeps the cursor there.
               if (new_row == ROW_LIMIT) begin
                  step.scroll   = 1'b1;
                  step.next_row = ROW_W'(ROWS - 1);
               end else begin
                  step.next_row = new_row[ROW_W-1:0];
               end
            end
         end
         OP_CLEAR: begin
            step.clear    = 1'b1;
            step.next_col = '0;
            step.next_row = '0;
         end
         OP_READ: begin
            step.coord_error = bad;
            step.rd_en       = !bad;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/text_console_writer_unit.sv @@
// Top level of the text console writer: cell store, sweep sequencer and
// handshakes. Depends on tcw_pkg and tcw_cursor_step.
`default_nettype none

// Usage
// An item arrives on req_* and is taken when req_valid is high and
// req_stall low; every item gives exactly one result on rsp_*, taken when
// rsp_valid is high and rsp_stall low. The block works on one item at a
// time, held in a single-port-write, single-port-read cell store with a
// registered read. Put, newline, backspace and unused ops go from idle
// straight to the done state; a read passes through a read state first,
// because the store's read is registered. A put that scrolls runs one
// row-up copy pass over the store, one cell a cycle, then a pass blanking
// the bottom row. Clear writes the whole store, one cell a cycle.
// The result register lets the next item be taken while a result still
// waits; if rsp_stall stays high the block holds its next result and
// stalls the request side until the first is taken.
// Reset homes the cursor and restores both attribute registers; cell
// contents are undefined until the first clear. csr_* writes are always
// taken and must only come while the block is idle.

module text_console_writer_unit
   import tcw_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [1:0]       req_op,
   input  wire logic [7:0]       req_char_code,
   input  wire logic [7:0]       req_attr,
   input  wire logic [COL_W-1:0] req_col,
   input  wire logic [ROW_W-1:0] req_row,
   input  wire logic             req_use_cursor,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [COL_W-1:0]      rsp_cursor_col,
   output logic [ROW_W-1:0]      rsp_cursor_row,
   output logic                  rsp_coord_error,
   output logic [7:0]            rsp_cell_char,
   output logic [7:0]            rsp_cell_attr,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic             csr_index,
   input  wire logic [7:0]       csr_data
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_READ   = 3'd1;
   localparam logic [2:0] S_SCROLL = 3'd2;
   localparam logic [2:0] S_BLANK  = 3'd3;
   localparam logic [2:0] S_CLEAR  = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   localparam logic [CELL_W-1:0] COPY_END = CELL_W'(CELLS - COLUMNS);
   localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELLS - 1);

   logic [15:0] cell_mem [CELLS];
   logic [15:0] mem_q_ff;

   logic [2:0]        state_ff, state_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [CELL_W-1:0] sweep_ff, sweep_in;
   logic              res_err_ff, res_err_in;
   logic [7:0]        res_char_ff, res_char_in;
   logic [7:0]        res_attr_ff, res_attr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic              rsp_err_ff, rsp_err_in;
   logic [7:0]        rsp_char_ff, rsp_char_in;
   logic [7:0]        rsp_attr_ff, rsp_attr_in;
   logic [7:0]        default_attr_ff, default_attr_in;
   logic [7:0]        error_attr_ff, error_attr_in;

   logic              mem_we;
   logic [CELL_W-1:0] mem_waddr;
   logic [15:0]       mem_wdata;
   logic              mem_re;
   logic [CELL_W-1:0] mem_raddr;
   logic              accept;
   step_type          step;

   tcw_cursor_step u_step (
      .op           (req_op),
      .char_code    (req_char_code),
      .attr         (req_attr),
      .col          (req_col),
      .row          (req_row),
      .use_cursor   (req_use_cursor),
      .cur_col      (cur_col_ff),
      .cur_row      (cur_row_ff),
      .default_attr (default_attr_ff),
      .error_attr   (error_attr_ff),
      .step         (step)
   );

   assign req_stall       = (state_ff != S_IDLE);
   assign accept          = req_valid && (state_ff == S_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cursor_col  = rsp_col_ff;
   assign rsp_cursor_row  = rsp_row_ff;
   assign rsp_coord_error = rsp_err_ff;
   assign rsp_cell_char   = rsp_char_ff;
   assign rsp_cell_attr   = rsp_attr_ff;

   always_comb begin
      state_in        = state_ff;
      cur_col_in      = cur_col_ff;
      cur_row_in      = cur_row_ff;
      sweep_in        = sweep_ff;
      res_err_in      = res_err_ff;
      res_char_in     = res_char_ff;
      res_attr_in     = res_attr_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_col_in      = rsp_col_ff;
      rsp_row_in      = rsp_row_ff;
      rsp_err_in      = rsp_err_ff;
      rsp_char_in     = rsp_char_ff;
      rsp_attr_in     = rsp_attr_ff;
      default_attr_in = default_attr_ff;
      error_attr_in   = error_attr_ff;
      mem_we          = 1'b0;
      mem_waddr       = step.wr_addr;
      mem_wdata       = step.wr_data;
      mem_re          = 1'b0;
      mem_raddr       = step.rd_addr;

      if (csr_valid) begin
         case (csr_index)
            CSR_DEFAULT_ATTR: default_attr_in = csr_data;
            CSR_ERROR_ATTR:   error_attr_in   = csr_data;
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mem_we      = step.wr_en;
               mem_re      = step.rd_en;
               cur_col_in  = step.next_col;
               cur_row_in  = step.next_row;
               res_err_in  = step.coord_error;
               res_char_in = 8'd0;
               res_attr_in = 8'd0;
               sweep_in    = '0;
               if (step.rd_en) begin
                  state_in = S_READ;
               end else if (step.scroll) begin
                  state_in = S_SCROLL;
               end else if (step.clear) begin
                  state_in = S_CLEAR;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_READ: begin
            res_char_in = mem_q_ff[7:0];
            res_attr_in = mem_q_ff[15:8];
            state_in    = S_DONE;
         end
         S_SCROLL: begin
            // Read one row ahead, write the data read last cycle one cell back.
            mem_re    = (sweep_ff != COPY_END);
            mem_raddr = sweep_ff + CELL_W'(COLUMNS);
            mem_we    = (sweep_ff != '0);
            mem_waddr = sweep_ff - 1'b1;
            mem_wdata = mem_q_ff;
            if (sweep_ff == COPY_END) begin
               state_in = S_BLANK;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         S_BLANK, S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = (state_ff == S_BLANK) ? {default_attr_ff, CH_BLANK}
                                              : {default_attr_ff, CH_SPACE};
            if (sweep_ff == LAST_CELL) begin
               state_in = S_DONE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = cur_col_ff;
               rsp_row_in   = cur_row_ff;
               rsp_err_in   = res_err_ff;
               rsp_char_in  = res_char_ff;
               rsp_attr_in  = res_attr_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= cell_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         cur_col_ff      <= '0;
         cur_row_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
         default_attr_ff <= DEFAULT_ATTR_RESET;
         error_attr_ff   <= ERROR_ATTR_RESET;
      end else begin
         state_ff        <= state_in;
         cur_col_ff      <= cur_col_in;
         cur_row_ff      <= cur_row_in;
         rsp_valid_ff    <= rsp_valid_in;
         default_attr_ff <= default_attr_in;
         error_attr_ff   <= error_attr_in;
      end
   end

   always_ff @(posedge clock) begin
      sweep_ff    <= sweep_in;
      res_err_ff  <= res_err_in;
      res_char_ff <= res_char_in;
      res_attr_ff <= res_attr_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_char_ff <= rsp_char_in;
      rsp_attr_ff <= rsp_attr_in;
   end

endmodule

`default_nettype wire
